### src/battery_voltage_monitor_assert.svh
// ============================================================================
// battery_voltage_monitor_assert
// Assertion macros shared by the battery voltage monitor RTL.
// ============================================================================
`ifndef BATTERY_VOLTAGE_MONITOR_ASSERT_SVH
`define BATTERY_VOLTAGE_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bvm_pkg.sv
// ============================================================================
// bvm_pkg
// Constants and codes shared by the battery voltage monitor.
// ============================================================================
`timescale 1ns / 1ps

package bvm_pkg;

    // Default averaging window length.
    localparam int WINDOW_LEN_DEF = 16;

    // ADC code to millivolt conversion: mv = floor(raw * CONV_GAIN / ADC_FULL).
    localparam logic [15:0] CONV_GAIN = 16'd36300;
    localparam logic [15:0] ADC_FULL  = 16'd65535;

    // Dividend width of the percent divider, enough for the scaled percent
    // numerator while full minus recharge stays at or below 41944 mV.
    localparam int DIV_W = 22;

    localparam logic [6:0] PCT_FULL  = 7'd100;
    localparam logic [6:0] PCT_EMPTY = 7'd0;

    // Battery state codes.
    localparam logic [1:0] BSTATE_NORMAL   = 2'd0;
    localparam logic [1:0] BSTATE_LOW      = 2'd1;
    localparam logic [1:0] BSTATE_CRITICAL = 2'd2;

    // Indicator colour classes.
    localparam logic [1:0] IND_RED    = 2'd0;
    localparam logic [1:0] IND_GREEN  = 2'd1;
    localparam logic [1:0] IND_ORANGE = 2'd2;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_CRITICAL = 3'd0;
    localparam logic [2:0] REG_RECHARGE = 3'd1;
    localparam logic [2:0] REG_FULL     = 3'd2;
    localparam logic [2:0] REG_GOOD     = 3'd3;
    localparam logic [2:0] REG_CONFIRM  = 3'd4;

    // Register reset values.
    localparam logic [15:0] CRITICAL_RST = 16'd9600;
    localparam logic [15:0] RECHARGE_RST = 16'd10500;
    localparam logic [15:0] FULL_RST     = 16'd12600;
    localparam logic [15:0] GOOD_RST     = 16'd11400;
    localparam logic [7:0]  CONFIRM_RST  = 8'd3;

    localparam logic [7:0] RUN_MAX = 8'hFF;

endpackage

### src/battery_voltage_monitor.sv
// ============================================================================
// battery_voltage_monitor
// Moving-average voltage monitor for a three-cell pack with state, charge
// percent and indicator class.
// ============================================================================
// Each item is one 16-bit ADC code; each item gives exactly one result. The
// block works on one item at a time: after an item is accepted it passes the
// multiply, convert, sum, average, evaluate and percent steps; when the charge
// percent clamps to 0 or 100 the result then goes to the output register, and
// otherwise it first passes the bit-serial divider, which retires one quotient
// bit per cycle over 22 bits and is used only for the percent; the window
// average comes from a single multiplication by a fixed reciprocal of the
// window length. A finished result waits in its own output register, so the
// next item may be accepted while it is still stalled; a result that finds
// that register still held waits in the last step for as long as the stall
// lasts. The first item after reset primes the window with its own value; no
// clearing pass is needed after reset.
`timescale 1ns / 1ps

module battery_voltage_monitor #(
    parameter int WINDOW_LEN = bvm_pkg::WINDOW_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] raw_sample,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] average_mv,
    output logic [1:0]  battery_state,
    output logic [6:0]  percent,
    output logic [1:0]  indicator,
    output logic [7:0]  low_run
);
    import bvm_pkg::*;

`include "battery_voltage_monitor_assert.svh"

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W  = 16 + SLOT_W;
    localparam int CNT_W  = $clog2(DIV_W);

    // Average by a fixed reciprocal: with the shift a window index wider than
    // the sum, the rounded-up reciprocal gives floor(sum / WINDOW_LEN) exactly.
    localparam int AVG_SHIFT = SUM_W + SLOT_W;
    localparam logic [SUM_W:0] AVG_RECIP = (SUM_W + 1)'(
        ((longint'(1) << AVG_SHIFT) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CONV,
        ST_SUM,
        ST_AVG,
        ST_EVAL,
        ST_PCT,
        ST_DIV_PCT,
        ST_FIN
    } seq_state_t;

    seq_state_t state_reg;

    // Configuration registers
    logic [15:0] critical_mv_reg;
    logic [15:0] recharge_mv_reg;
    logic [15:0] full_mv_reg;
    logic [15:0] good_mv_reg;
    logic [7:0]  confirm_count_reg;

    // Window state. Entries not written since priming read as the prime value,
    // which is held apart; wrapped_reg says every entry has been written.
    logic [15:0]       window_mem [WINDOW_LEN];
    logic [15:0]       rd_data_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [15:0]       prime_mv_reg;
    logic              primed_reg;
    logic              wrapped_reg;
    logic [7:0]        run_reg;

    // Working registers of the current item
    logic [15:0] raw_reg;
    logic [31:0] prod_reg;
    logic [15:0] mv_reg;
    logic [15:0] avg_reg;
    logic [DIV_W-1:0] pct_num_reg;
    logic        le_rec_reg;
    logic        ge_full_reg;
    logic [1:0]  bstate_reg;
    logic [1:0]  ind_reg;
    logic [6:0]  pct_reg;

    // Percent divider
    logic [15:0]      rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [15:0]      dvs_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Output register
    logic        out_valid_reg;
    logic [15:0] average_mv_reg;
    logic [1:0]  battery_state_reg;
    logic [6:0]  percent_reg;
    logic [1:0]  indicator_reg;
    logic [7:0]  low_run_reg;

    logic        in_accept;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic        out_load;

    // Conversion correction: x = q0*65536 + lo = q0*65535 + (q0 + lo), and
    // q0 + lo stays below twice the divisor, so one compare settles it.
    logic [15:0] conv_q0;
    logic [16:0] conv_rem;
    logic [15:0] mv_calc;

    logic [15:0]      old_mv;
    logic [SUM_W-1:0] sum_next;
    logic [7:0]       run_next;
    logic [2*SUM_W:0] avg_prod;

    logic [16:0]      div_trial;
    logic             div_take;
    logic [15:0]      rem_next;
    logic [DIV_W-1:0] quo_next;

    logic [15:0] avg_excess;
    logic [22:0] pct_prod;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        case (cfg_index)
            REG_CRITICAL: prdata = {16'd0, critical_mv_reg};
            REG_RECHARGE: prdata = {16'd0, recharge_mv_reg};
            REG_FULL:     prdata = {16'd0, full_mv_reg};
            REG_GOOD:     prdata = {16'd0, good_mv_reg};
            REG_CONFIRM:  prdata = {24'd0, confirm_count_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign conv_q0  = prod_reg[31:16];
    assign conv_rem = {1'b0, prod_reg[15:0]} + {1'b0, conv_q0};
    assign mv_calc  = conv_q0 + ((conv_rem >= {1'b0, ADC_FULL}) ? 16'd1 : 16'd0);

    assign old_mv   = wrapped_reg ? rd_data_reg : prime_mv_reg;
    assign sum_next = primed_reg
                    ? (sum_reg - SUM_W'(old_mv) + SUM_W'(mv_reg))
                    : (SUM_W'(mv_reg) * SUM_W'(WINDOW_LEN));

    assign avg_prod = sum_reg * AVG_RECIP;

    always_comb
    begin
        if (mv_reg <= critical_mv_reg)
        begin
            run_next = (run_reg == RUN_MAX) ? run_reg : run_reg + 8'd1;
        end
        else
        begin
            run_next = 8'd0;
        end
    end

    // One restoring division step.
    assign div_trial = {rem_reg, quo_reg[DIV_W-1]};
    assign div_take  = (div_trial >= {1'b0, dvs_reg});
    assign rem_next  = div_take ? 16'(div_trial - {1'b0, dvs_reg}) : div_trial[15:0];
    assign quo_next  = {quo_reg[DIV_W-2:0], div_take};

    assign avg_excess = avg_reg - recharge_mv_reg;
    assign pct_prod   = avg_excess * PCT_FULL;

    // Window memory: registered read of the oldest entry, single write.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            rd_data_reg <= window_mem[slot_reg];
        end
        if (state_reg == ST_SUM && primed_reg)
        begin
            window_mem[slot_reg] <= mv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            critical_mv_reg   <= CRITICAL_RST;
            recharge_mv_reg   <= RECHARGE_RST;
            full_mv_reg       <= FULL_RST;
            good_mv_reg       <= GOOD_RST;
            confirm_count_reg <= CONFIRM_RST;
            slot_reg          <= '0;
            sum_reg           <= '0;
            prime_mv_reg      <= '0;
            primed_reg        <= 1'b0;
            wrapped_reg       <= 1'b0;
            run_reg           <= '0;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CRITICAL: critical_mv_reg   <= pwdata[15:0];
                    REG_RECHARGE: recharge_mv_reg   <= pwdata[15:0];
                    REG_FULL:     full_mv_reg       <= pwdata[15:0];
                    REG_GOOD:     good_mv_reg       <= pwdata[15:0];
                    REG_CONFIRM:  confirm_count_reg <= pwdata[7:0];
                    default:      ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        raw_reg   <= raw_sample;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= 32'(raw_reg) * 32'(CONV_GAIN);
                    state_reg <= ST_CONV;
                end
                ST_CONV:
                begin
                    mv_reg    <= mv_calc;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    sum_reg <= sum_next;
                    run_reg <= run_next;
                    if (!primed_reg)
                    begin
                        prime_mv_reg <= mv_reg;
                        primed_reg   <= 1'b1;
                        wrapped_reg  <= 1'b0;
                        slot_reg     <= '0;
                    end
                    else if (slot_reg == SLOT_W'(WINDOW_LEN - 1))
                    begin
                        slot_reg    <= '0;
                        wrapped_reg <= 1'b1;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                    state_reg <= ST_AVG;
                end
                ST_AVG:
                begin
                    avg_reg   <= avg_prod[AVG_SHIFT +: 16];
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    pct_num_reg <= pct_prod[DIV_W-1:0];
                    le_rec_reg  <= (avg_reg <= recharge_mv_reg);
                    ge_full_reg <= (avg_reg >= full_mv_reg);
                    if (run_reg >= confirm_count_reg)
                    begin
                        bstate_reg <= BSTATE_CRITICAL;
                        ind_reg    <= IND_RED;
                    end
                    else if (avg_reg <= recharge_mv_reg)
                    begin
                        bstate_reg <= BSTATE_LOW;
                        ind_reg    <= IND_RED;
                    end
                    else
                    begin
                        bstate_reg <= BSTATE_NORMAL;
                        ind_reg    <= (avg_reg >= good_mv_reg) ? IND_GREEN : IND_ORANGE;
                    end
                    state_reg <= ST_PCT;
                end
                ST_PCT:
                begin
                    if (le_rec_reg)
                    begin
                        pct_reg   <= PCT_EMPTY;
                        state_reg <= ST_FIN;
                    end
                    else if (ge_full_reg)
                    begin
                        pct_reg   <= PCT_FULL;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        // Here recharge < average < full, so the divisor is positive.
                        rem_reg   <= '0;
                        quo_reg   <= pct_num_reg;
                        dvs_reg   <= full_mv_reg - recharge_mv_reg;
                        cnt_reg   <= CNT_W'(DIV_W - 1);
                        state_reg <= ST_DIV_PCT;
                    end
                end
                ST_DIV_PCT:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    if (cnt_reg == '0)
                    begin
                        pct_reg   <= quo_next[6:0];
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_FIN:
                begin
                    // Load the output register once the previous result has gone.
                    if (out_load)
                    begin
                        average_mv_reg    <= avg_reg;
                        battery_state_reg <= bstate_reg;
                        percent_reg       <= pct_reg;
                        indicator_reg     <= ind_reg;
                        low_run_reg       <= run_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign average_mv    = average_mv_reg;
    assign battery_state = battery_state_reg;
    assign percent       = percent_reg;
    assign indicator     = indicator_reg;
    assign low_run       = low_run_reg;

    `BVM_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, state_reg == ST_MUL, "accepted item did not start the sequencer")
    `BVM_ASSERT_NOW(a_div_cnt_idle, clk, rst_n, (cnt_reg != '0), (state_reg == ST_DIV_PCT), "divider count left running outside a division")
    `BVM_ASSERT_NOW(a_slot_range, clk, rst_n, 1'b1, slot_reg <= SLOT_W'(WINDOW_LEN - 1), "window slot beyond the window")
    `BVM_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid_reg, percent_reg <= PCT_FULL, "percent above one hundred")
    `BVM_ASSERT_NOW(a_red_not_normal, clk, rst_n, (out_valid_reg && battery_state_reg != BSTATE_NORMAL), indicator_reg == IND_RED, "low or critical state not shown red")

endmodule
